// ===== rtl/irn_pkg.sv =====
`timescale 1ns / 1ps

package irn_pkg;

    // Field widths
    localparam int unsigned ValueWidth  = 14;
    localparam int unsigned SymbolWidth = 7;

    // Largest value that has a numeral
    localparam logic [ValueWidth-1:0] MaxValue = 14'd3999;

    // Decimal weights
    localparam logic [ValueWidth-1:0] Thousand1 = 14'd1000;
    localparam logic [ValueWidth-1:0] Thousand2 = 14'd2000;
    localparam logic [ValueWidth-1:0] Thousand3 = 14'd3000;

    // Reciprocal multipliers: x/100 = (x*41)>>12 for x < 1024,
    // x/10 = (x*205)>>11 for x < 128
    localparam logic [5:0] Recip100 = 6'd41;
    localparam logic [7:0] Recip10  = 8'd205;

    // ASCII letters
    localparam logic [SymbolWidth-1:0] ChrI = 7'h49;
    localparam logic [SymbolWidth-1:0] ChrV = 7'h56;
    localparam logic [SymbolWidth-1:0] ChrX = 7'h58;
    localparam logic [SymbolWidth-1:0] ChrL = 7'h4C;
    localparam logic [SymbolWidth-1:0] ChrC = 7'h43;
    localparam logic [SymbolWidth-1:0] ChrD = 7'h44;
    localparam logic [SymbolWidth-1:0] ChrM = 7'h4D;
    localparam logic [SymbolWidth-1:0] ChrNone = 7'h00;

    // Digit positions, most significant first
    typedef enum logic [1:0] {
        POS_THOU  = 2'd0,
        POS_HUND  = 2'd1,
        POS_TENS  = 2'd2,
        POS_UNITS = 2'd3
    } t_pos;

    // Letter role within a digit's triple
    typedef enum logic [1:0] {
        ROLE_UNIT = 2'd0,
        ROLE_FIVE = 2'd1,
        ROLE_TEN  = 2'd2
    } t_role;

    // Decimal digits of one value, plus its range error
    typedef struct packed {
        logic [3:0] thou;
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] units;
        logic       err;
    } t_digits;

    // Letters emitted for one decimal digit
    function automatic logic [2:0] digit_len(input logic [3:0] d);
        logic [2:0] len;
        case (d)
            4'd1:    len = 3'd1;
            4'd2:    len = 3'd2;
            4'd3:    len = 3'd3;
            4'd4:    len = 3'd2;
            4'd5:    len = 3'd1;
            4'd6:    len = 3'd2;
            4'd7:    len = 3'd3;
            4'd8:    len = 3'd4;
            4'd9:    len = 3'd2;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    // Which letter of the triple is the k-th letter of digit d
    function automatic t_role digit_role(input logic [3:0] d, input logic [1:0] k);
        t_role role;
        if (d == 4'd9) begin
            role = (k == 2'd0) ? ROLE_UNIT : ROLE_TEN;
        end else if (d == 4'd4) begin
            role = (k == 2'd0) ? ROLE_UNIT : ROLE_FIVE;
        end else if (d >= 4'd5 && k == 2'd0) begin
            role = ROLE_FIVE;
        end else begin
            role = ROLE_UNIT;
        end
        return role;
    endfunction

    // Letter triple per position: I/V/X, X/L/C, C/D/M, M only
    function automatic logic [SymbolWidth-1:0] letter(input t_pos pos, input t_role role);
        logic [SymbolWidth-1:0] ch;
        case (pos)
            POS_THOU: ch = ChrM;
            POS_HUND: begin
                case (role)
                    ROLE_UNIT: ch = ChrC;
                    ROLE_FIVE: ch = ChrD;
                    default:   ch = ChrM;
                endcase
            end
            POS_TENS: begin
                case (role)
                    ROLE_UNIT: ch = ChrX;
                    ROLE_FIVE: ch = ChrL;
                    default:   ch = ChrC;
                endcase
            end
            default: begin
                case (role)
                    ROLE_UNIT: ch = ChrI;
                    ROLE_FIVE: ch = ChrV;
                    default:   ch = ChrX;
                endcase
            end
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/irn_split.sv =====
`timescale 1ns / 1ps

// Decimal split pipeline: input register, thousands, hundreds, tens/units.
module irn_split
    import irn_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [ValueWidth-1:0] i_value,
    output logic                  o_ready,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_digits               o_digits
);

    // Stage valids
    logic r_v0, r_v1, r_v2, r_v3;
    logic move0, move1, move2, move3;

    // Stage 0: input register
    logic [ValueWidth-1:0] r_value;

    // Stage 1: thousands and remainder below 1000
    logic [3:0] r_thou1;
    logic [9:0] r_rem1;
    logic       r_err1;

    // Stage 2: hundreds and remainder below 100
    logic [3:0] r_thou2;
    logic [3:0] r_hund2;
    logic [6:0] r_rem2;
    logic       r_err2;

    // Stage 3: all four digits
    t_digits r_digits;

    // Stall chain from the serializer back to the input
    assign move3   = !r_v3 || i_ready;
    assign move2   = !r_v2 || move3;
    assign move1   = !r_v1 || move2;
    assign move0   = !r_v0 || move1;
    assign o_ready = move0;
    assign o_valid = r_v3;
    assign o_digits = r_digits;

    // Thousands by compare ladder
    logic [3:0]            n_thou1;
    logic [ValueWidth-1:0] n_sub1;
    logic [ValueWidth-1:0] n_diff1;
    always_comb begin
        if (r_value >= Thousand3) begin
            n_thou1 = 4'd3;
            n_sub1  = Thousand3;
        end else if (r_value >= Thousand2) begin
            n_thou1 = 4'd2;
            n_sub1  = Thousand2;
        end else if (r_value >= Thousand1) begin
            n_thou1 = 4'd1;
            n_sub1  = Thousand1;
        end else begin
            n_thou1 = 4'd0;
            n_sub1  = '0;
        end
        n_diff1 = r_value - n_sub1;
    end

    // Hundreds by reciprocal multiply
    logic [15:0] n_prod2;
    logic [3:0]  n_hund2;
    logic [9:0]  n_back2;
    logic [9:0]  n_diff2;
    always_comb begin
        n_prod2 = 16'(r_rem1) * 16'(Recip100);
        n_hund2 = n_prod2[15:12];
        n_back2 = 10'(n_hund2) * 10'd100;
        n_diff2 = r_rem1 - n_back2;
    end

    // Tens by reciprocal multiply, units as what is left
    logic [14:0] n_prod3;
    logic [3:0]  n_tens3;
    logic [6:0]  n_back3;
    logic [6:0]  n_diff3;
    always_comb begin
        n_prod3 = 15'(r_rem2) * 15'(Recip10);
        n_tens3 = n_prod3[14:11];
        n_back3 = 7'(n_tens3) * 7'd10;
        n_diff3 = r_rem2 - n_back3;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (move0) r_v0 <= i_valid;
            if (move1) r_v1 <= r_v0;
            if (move2) r_v2 <= r_v1;
            if (move3) r_v3 <= r_v2;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (move0) begin
            r_value <= i_value;
        end
        if (move1) begin
            r_thou1 <= n_thou1;
            r_rem1  <= n_diff1[9:0];
            r_err1  <= (r_value == '0) || (r_value > MaxValue);
        end
        if (move2) begin
            r_thou2 <= r_thou1;
            r_hund2 <= n_hund2;
            r_rem2  <= n_diff2[6:0];
            r_err2  <= r_err1;
        end
        if (move3) begin
            r_digits.thou  <= r_thou2;
            r_digits.hund  <= r_hund2;
            r_digits.tens  <= n_tens3;
            r_digits.units <= n_diff3[3:0];
            r_digits.err   <= r_err2;
        end
    end

endmodule

// ===== rtl/irn_emit.sv =====
`timescale 1ns / 1ps

// Serializer: walks the digits of one value and emits one letter per cycle.
module irn_emit
    import irn_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  t_digits                i_digits,
    output logic                   o_ready,
    output logic                   o_strobe,
    output logic [SymbolWidth-1:0] o_symbol,
    output logic                   o_last,
    output logic                   o_out_of_range
);

    logic       r_act;
    t_digits    r_dig;
    t_pos       r_pos;
    logic [1:0] r_k;

    // Nonzero mask per position, thousands in bit 0
    function automatic logic [3:0] nz_mask(input t_digits d);
        return {d.units != 4'd0, d.tens != 4'd0, d.hund != 4'd0, d.thou != 4'd0};
    endfunction

    logic [3:0]             cur_nz;
    logic [3:0]             cur_digit;
    logic [2:0]             cur_len;
    logic                   later_nz;
    t_pos                   next_pos;
    logic                   end_digit;
    logic                   is_last;
    logic [SymbolWidth-1:0] cur_char;
    logic [3:0]             in_nz;
    t_pos                   first_pos;
    logic                   load;

    // Current letter and whether it closes the numeral
    always_comb begin
        cur_nz = nz_mask(r_dig);
        case (r_pos)
            POS_THOU: cur_digit = r_dig.thou;
            POS_HUND: cur_digit = r_dig.hund;
            POS_TENS: cur_digit = r_dig.tens;
            default:  cur_digit = r_dig.units;
        endcase
        cur_len   = digit_len(cur_digit);
        cur_char  = letter(r_pos, digit_role(cur_digit, r_k));
        end_digit = (3'(r_k) + 3'd1) >= cur_len;

        // Next nonzero position after the current one
        later_nz = 1'b0;
        next_pos = POS_UNITS;
        for (int i = 3; i >= 0; i--) begin
            if (2'(i) > r_pos && cur_nz[i]) begin
                later_nz = 1'b1;
                next_pos = t_pos'(2'(i));
            end
        end
        is_last = r_dig.err || (end_digit && !later_nz);
    end

    // First nonzero position of an incoming value
    always_comb begin
        in_nz     = nz_mask(i_digits);
        first_pos = POS_UNITS;
        for (int i = 3; i >= 0; i--) begin
            if (in_nz[i]) first_pos = t_pos'(2'(i));
        end
    end

    assign o_ready = !r_act || is_last;
    assign load    = i_valid && o_ready;

    // Walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (load) begin
            r_act <= 1'b1;
        end else if (is_last) begin
            r_act <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_dig <= i_digits;
            r_pos <= first_pos;
            r_k   <= 2'd0;
        end else if (r_act && !is_last) begin
            if (end_digit) begin
                r_pos <= next_pos;
                r_k   <= 2'd0;
            end else begin
                r_k <= r_k + 2'd1;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_act;
        end
    end

    always_ff @(posedge i_clk) begin
        o_symbol       <= r_dig.err ? ChrNone : cur_char;
        o_last         <= is_last;
        o_out_of_range <= r_dig.err;
    end

endmodule

// ===== rtl/integer_to_roman_numeral.sv =====
`timescale 1ns / 1ps

// Channel   Transfer when             Payload
// -------   -----------------------   -------------------------------------------
// input     start && !busy            i_value[13:0]
// result    o_strobe (one cycle)      o_symbol[6:0], o_last, o_out_of_range
//
// A value's numeral has 1 to 15 letters, sent one letter per cycle from the
// serializer; an out-of-range value gives a single result.
// The first letter reaches the ports through the four split stages, the
// serializer and the result register. A new value is taken while the previous
// one's last letter is leaving. Synchronous active-low reset clears all valids.
// Results cannot be held off; busy backs up through the split pipeline.
module integer_to_roman_numeral
    import irn_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [ValueWidth-1:0]  i_value,
    output logic                   o_strobe,
    output logic [SymbolWidth-1:0] o_symbol,
    output logic                   o_last,
    output logic                   o_out_of_range
);

    logic    split_ready;
    logic    split_valid;
    logic    emit_ready;
    t_digits split_digits;

    assign busy = !split_ready;

    irn_split u_split (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start),
        .i_value  (i_value),
        .o_ready  (split_ready),
        .o_valid  (split_valid),
        .i_ready  (emit_ready),
        .o_digits (split_digits)
    );

    irn_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (split_valid),
        .i_digits       (split_digits),
        .o_ready        (emit_ready),
        .o_strobe       (o_strobe),
        .o_symbol       (o_symbol),
        .o_last         (o_last),
        .o_out_of_range (o_out_of_range)
    );

endmodule
